// ----- src/plr_pkg.sv -----
`timescale 1ns / 1ps

package plr_pkg;

    // Grid geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);

    // Field widths
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 32;
    localparam int RES_W     = 36;

    // Effective dimensions are held at the width of the config registers
    localparam int DIM_W = CFG_W;
    localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    // Read sequence: one grid read per step, data lands one step later
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_LEFT   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_RIGHT  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_UP     = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_DOWN   = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_CENTER = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_DONE   = STEP_W'(5);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EMIT
    } state_t;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] d;
        begin
            if (r == '0) begin
                d = DIM_ONE;
            end else if (r > maxv) begin
                d = maxv;
            end else begin
                d = r;
            end
            return d;
        end
    endfunction

    // Row-major cell address
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        begin
            return ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
        end
    endfunction

endpackage

// ----- src/periodic_laplacian_residual_top.sv -----
`timescale 1ns / 1ps
// Load item: written to the grid RAM in its accept cycle, no result.
// Query item in range: the result is built from five reads of the single-port grid
// RAM, whose read data is registered, accumulated through one shared 36-bit adder.
// Query item out of range: goes straight to the error result. Reset clears control and config only;
// the grid RAM is not cleared and holds garbage until cells are loaded.

module periodic_laplacian_residual_top
    import plr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    // config write port
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [IDX_W-1:0]            s_row,
    input  logic [IDX_W-1:0]            s_col,
    input  logic signed [VAL_W-1:0]     s_value,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RES_W-1:0]     m_residual,
    output logic                        m_status
);

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CFG_W-1:0]   grid_width_reg, grid_height_reg;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [IDX_W-1:0]   left_reg, left_next;
    logic [IDX_W-1:0]   right_reg, right_next;
    logic [IDX_W-1:0]   up_reg, up_next;
    logic [IDX_W-1:0]   down_reg, down_next;
    logic signed [RES_W-1:0] acc_reg, acc_next;
    logic               err_reg, err_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [RES_W-1:0] m_residual_reg, m_residual_next;
    logic               m_status_reg, m_status_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [VAL_W-1:0]   ram_rdata;

    logic [DIM_W-1:0]   eff_w, eff_h;
    logic [DIM_W-1:0]   row_x, col_x;
    logic signed [RES_W-1:0] rd_ext, operand;
    logic               load_in_grid;

    plr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_value),
        .rdata (ram_rdata)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_residual = m_residual_reg;
    assign m_status   = m_status_reg;

    assign eff_w = eff_dim(grid_width_reg, DIM_MAX_W);
    assign eff_h = eff_dim(grid_height_reg, DIM_MAX_H);
    assign row_x = DIM_W'(row_reg);
    assign col_x = DIM_W'(col_reg);

    assign load_in_grid = (DIM_W'(s_row) < DIM_MAX_H) && (DIM_W'(s_col) < DIM_MAX_W);

    // Shared adder operand: neighbors subtract, center adds four times
    assign rd_ext  = RES_W'($signed(ram_rdata));
    assign operand = (step_reg == STEP_DONE) ? (rd_ext <<< 2) : -rd_ext;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= DIM_MAX_W;
            grid_height_reg <= DIM_MAX_H;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_LEFT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        up_reg         <= up_next;
        down_reg       <= down_next;
        acc_reg        <= acc_next;
        err_reg        <= err_next;
        m_residual_reg <= m_residual_next;
        m_status_reg   <= m_status_next;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        up_next         = up_reg;
        down_next       = down_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_residual_next = m_residual_reg;
        m_status_next   = m_status_reg;
        ram_we          = 1'b0;
        ram_addr        = cell_addr(row_reg, col_reg);

        unique case (state_reg)
            ST_IDLE: begin
                ram_addr = cell_addr(s_row, s_col);
                if (s_valid) begin
                    if (s_command == CMD_LOAD) begin
                        ram_we = load_in_grid;
                    end else begin
                        row_next   = s_row;
                        col_next   = s_col;
                        acc_next   = RES_W'(s_value);
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK: begin
                // neighbor indices with periodic wrap
                left_next  = (col_reg == '0) ? IDX_W'(eff_w - DIM_ONE) : col_reg - 1'b1;
                right_next = (col_x + DIM_ONE == eff_w) ? '0 : col_reg + 1'b1;
                up_next    = (row_x + DIM_ONE == eff_h) ? '0 : row_reg + 1'b1;
                down_next  = (row_reg == '0) ? IDX_W'(eff_h - DIM_ONE) : row_reg - 1'b1;
                step_next  = STEP_LEFT;
                if (row_x >= eff_h || col_x >= eff_w) begin
                    err_next   = 1'b1;
                    acc_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    err_next   = 1'b0;
                    state_next = ST_READ;
                end
            end

            ST_READ: begin
                // issue one read per step
                case (step_reg)
                    STEP_LEFT:  ram_addr = cell_addr(row_reg, left_reg);
                    STEP_RIGHT: ram_addr = cell_addr(row_reg, right_reg);
                    STEP_UP:    ram_addr = cell_addr(up_reg, col_reg);
                    STEP_DOWN:  ram_addr = cell_addr(down_reg, col_reg);
                    default:    ram_addr = cell_addr(row_reg, col_reg);
                endcase
                // accumulate the word read in the previous step
                if (step_reg != STEP_LEFT) begin
                    acc_next = acc_reg + operand;
                end
                if (step_reg == STEP_DONE) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            ST_EMIT: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_residual_next = acc_reg;
                    m_status_next   = err_reg;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Checks
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_residual == '0))
        else $error("error result carries nonzero residual");

    a_we_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE && s_command == CMD_LOAD))
        else $error("grid write outside an accepted load");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (step_reg <= STEP_DONE))
        else $error("read step counter overran");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!m_valid || m_ready)) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not presented after emit");

endmodule

// ----- src/plr_ram.sv -----
`timescale 1ns / 1ps

module plr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
